>>> sv/ffh_pkg.sv
// ----------------------------------------------------------------------------
// ffh_pkg
// Shared types and constants for the frame fragmenter with header.
// ----------------------------------------------------------------------------
package ffh_pkg;

    localparam int unsigned MAX_LINK_MTU   = 517;
    localparam int unsigned HDR_BYTES      = 3;
    localparam int unsigned MTU_W          = 10;
    localparam int unsigned LINK_MTU_RESET = 23;
    localparam int unsigned QUEUE_DEPTH    = 4;

    // Payload byte classified by the front end, with the header it needs.
    typedef struct packed {
        logic [7:0]  data;
        logic        close;
        logic        hdr;
        logic [15:0] pkt_num;
        logic [7:0]  frag_idx;
    } t_entry;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Payload limit for a given link MTU: clamp, strip header, floor of one.
    function automatic logic [MTU_W-1:0] limit_of(input logic [MTU_W-1:0] mtu);
        logic [MTU_W-1:0] eff;
        eff = mtu;
        if (MTU_W'(MAX_LINK_MTU) < mtu && MAX_LINK_MTU < (1 << MTU_W))
            eff = MTU_W'(MAX_LINK_MTU);
        if (eff <= MTU_W'(HDR_BYTES))
            return MTU_W'(1);
        return eff - MTU_W'(HDR_BYTES);
    endfunction

endpackage

>>> sv/ffh_front.sv
// ----------------------------------------------------------------------------
// ffh_front
// Accepts payload bytes, tracks packet numbering and fill, and queues each
// byte with its header information and close flag.
// ----------------------------------------------------------------------------
module ffh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_payload_byte,
    input  logic                i_frame_end,
    input  logic                i_link_mtu_we,
    input  logic [9:0]          i_link_mtu,
    input  ffh_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output ffh_pkg::t_entry     o_entry
);
    import ffh_pkg::*;

    logic [MTU_W-1:0] r_limit;
    logic [15:0]      r_pkt_num;
    logic [7:0]       r_frag_idx;
    logic [MTU_W-1:0] r_bip;

    logic [MTU_W-1:0] n_bip;
    logic [15:0]      n_pkt_num;
    logic [7:0]       n_frag_idx;
    logic [MTU_W-1:0] count;
    logic             hdr;
    logic             close;
    logic             accept;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept;

    assign hdr   = (r_bip == '0);
    assign count = r_bip + MTU_W'(1);
    assign close = i_frame_end || (count >= r_limit);

    always_comb begin
        o_entry.data     = i_payload_byte;
        o_entry.close    = close;
        o_entry.hdr      = hdr;
        o_entry.pkt_num  = r_pkt_num;
        o_entry.frag_idx = r_frag_idx;

        n_bip      = close ? '0 : count;
        n_pkt_num  = hdr ? r_pkt_num + 16'd1 : r_pkt_num;
        n_frag_idx = i_frame_end ? '0 : (hdr ? r_frag_idx + 8'd1 : r_frag_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= limit_of(MTU_W'(LINK_MTU_RESET));
            r_pkt_num  <= '0;
            r_frag_idx <= '0;
            r_bip      <= '0;
        end else begin
            if (i_link_mtu_we) begin
                r_limit <= limit_of(i_link_mtu);
            end
            if (accept) begin
                r_pkt_num  <= n_pkt_num;
                r_frag_idx <= n_frag_idx;
                r_bip      <= n_bip;
            end
        end
    end

endmodule

>>> sv/ffh_queue.sv
// ----------------------------------------------------------------------------
// ffh_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module ffh_queue #(
    parameter int unsigned DEPTH = ffh_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ffh_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output ffh_pkg::t_entry     o_head,
    output ffh_pkg::t_q_status  o_status
);
    import ffh_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry           r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_slots[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> sv/ffh_back.sv
// ----------------------------------------------------------------------------
// ffh_back
// Unrolls each queued byte into its payload byte, led by its header bytes if
// it opens a packet. Registered output; one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ffh_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffh_pkg::t_entry     i_head,
    input  ffh_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_packet_end,
    output logic                o_run_last
);
    import ffh_pkg::*;

    localparam logic [1:0] PH_PAYLOAD = 2'(HDR_BYTES);

    logic [1:0] r_phase;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_pend;
    logic       r_last;

    logic       load;
    logic       emit;
    logic       is_payload;
    logic [7:0] n_byte;

    assign load       = !r_valid || !i_out_stall;
    assign emit       = load && !i_q_status.empty;
    assign is_payload = !i_head.hdr || (r_phase == PH_PAYLOAD);
    assign o_pop      = emit && is_payload;

    always_comb begin
        if (is_payload) begin
            n_byte = i_head.data;
        end else begin
            unique case (r_phase)
                2'd0:    n_byte = i_head.pkt_num[7:0];
                2'd1:    n_byte = i_head.pkt_num[15:8];
                default: n_byte = i_head.frag_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= emit;
            end
            if (emit) begin
                r_phase <= is_payload ? '0 : r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_pend <= is_payload && i_head.close;
            r_last <= is_payload;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_packet_end = r_pend;
    assign o_run_last   = r_last;

endmodule

>>> sv/frame_fragmenter_with_header.sv
// ----------------------------------------------------------------------------
// frame_fragmenter_with_header
// Cuts a frame byte stream into packets, each led by a 3-byte sequence header.
// ----------------------------------------------------------------------------
// Input bytes go one per cycle, while there is room, into a short queue; the
// output side sends one byte per cycle unless stalled, so a byte that opens a
// packet occupies the output for packet number low, high, fragment index and
// payload, and any other byte for its payload only. The output stage is the
// throughput limit: a packet of N payload bytes gives N+3 output bytes. Input
// stalls only when the queue of QUEUE_DEPTH bytes is full.
// ----------------------------------------------------------------------------
module frame_fragmenter_with_header #(
    parameter int unsigned QUEUE_DEPTH = ffh_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_payload_byte,
    input  logic       i_frame_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_packet_end,
    output logic       o_run_last,
    input  logic       i_link_mtu_we,
    input  logic [9:0] i_link_mtu
);
    import ffh_pkg::*;

    t_entry    push_entry;
    t_entry    head;
    t_q_status q_status;
    logic      push;
    logic      pop;

    ffh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_payload_byte (i_payload_byte),
        .i_frame_end    (i_frame_end),
        .i_link_mtu_we  (i_link_mtu_we),
        .i_link_mtu     (i_link_mtu),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    ffh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    ffh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last)
    );

endmodule

>>> sv/ffh_checker.sv
// ----------------------------------------------------------------------------
// ffh_checker
// Port-level checks on the fragmenter, bound to the top level.
// ----------------------------------------------------------------------------
module ffh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_packet_end,
    input logic       o_run_last
);

    // a held transaction keeps its byte and flags
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_packet_end) && $stable(o_run_last))
        else $error("output changed while stalled");

    // header bytes never close a packet
    a_pend_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |-> o_run_last)
        else $error("packet end on a header byte");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled straight after reset");

endmodule

bind frame_fragmenter_with_header ffh_checker u_ffh_checker (.*);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame fragmenter with sequence header.
// ----------------------------------------------------------------------------
// Payload bytes go in with random bursts and gaps while the output side
// stalls on its own pattern. A behavioural predictor keeps its own packet
// number, fragment index and packet fill. It queues the header and payload
// bytes that each accepted transaction should produce, and every output
// transaction is checked against the oldest entry. The link MTU is changed
// only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       run_last;
    } t_out_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_payload_byte = 8'h00;
    logic       i_frame_end = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_packet_end;
    logic       o_run_last;
    logic       i_link_mtu_we = 1'b0;
    logic [9:0] i_link_mtu = 10'd0;

    // predictor state
    logic [15:0] pkt_num;
    logic [7:0]  frag_idx;
    logic [9:0]  open_bytes;
    logic [9:0]  mtu_setting;
    t_out_byte   expected_bytes[$];

    int errors = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int stall_pct = 30;

    frame_fragmenter_with_header dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_payload_byte (i_payload_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_packet_end   (o_packet_end),
        .o_run_last     (o_run_last),
        .i_link_mtu_we  (i_link_mtu_we),
        .i_link_mtu     (i_link_mtu)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        if (errors < 40)
            $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
        errors++;
    endtask

    // Expected output bytes for one accepted payload byte.
    function automatic void fragment_byte(input logic [7:0] data, input logic fe);
        logic [9:0] eff;
        logic [9:0] lim;
        logic [9:0] count;
        logic       close;
        eff = (mtu_setting > 10'(ffh_pkg::MAX_LINK_MTU)) ? 10'(ffh_pkg::MAX_LINK_MTU)
                                                         : mtu_setting;
        if (eff <= 10'(ffh_pkg::HDR_BYTES))
            lim = 10'd1;
        else
            lim = eff - 10'(ffh_pkg::HDR_BYTES);
        if (open_bytes == 10'd0) begin
            expected_bytes.push_back('{data: pkt_num[7:0], pkt_end: 1'b0, run_last: 1'b0});
            expected_bytes.push_back('{data: pkt_num[15:8], pkt_end: 1'b0, run_last: 1'b0});
            expected_bytes.push_back('{data: frag_idx, pkt_end: 1'b0, run_last: 1'b0});
            pkt_num  = pkt_num + 16'd1;
            frag_idx = frag_idx + 8'd1;
        end
        count = open_bytes + 10'd1;
        close = fe || (count >= lim);
        expected_bytes.push_back('{data: data, pkt_end: close, run_last: 1'b1});
        open_bytes = close ? 10'd0 : count;
        if (fe)
            frag_idx = 8'd0;
    endfunction

    // Output side: check each transaction, then pick the next stall value.
    always @(posedge i_clk) begin : out_check
        t_out_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected output byte", 16'h0, {8'h0, o_out_byte});
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", {8'h0, want.data}, {8'h0, o_out_byte});
                if (o_packet_end !== want.pkt_end)
                    report_mismatch("packet_end", {15'h0, want.pkt_end}, {15'h0, o_packet_end});
                if (o_run_last !== want.run_last)
                    report_mismatch("run_last", {15'h0, want.run_last}, {15'h0, o_run_last});
            end
        end
        // quiet stretch while cycle_count[9:8] is zero, random stalls otherwise
        i_out_stall <= (cycle_count[9:8] != 2'd0) && ($urandom_range(99) < stall_pct);
    end

    task automatic send_byte(input logic [7:0] data, input logic fe);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = 0;
            if (gaps_on && $urandom_range(2) != 0)
                gap = $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_payload_byte <= data;
        i_frame_end    <= fe;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fragment_byte(data, fe);
        burst_left--;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mtu(input logic [9:0] value);
        wait_idle();
        i_link_mtu_we <= 1'b1;
        i_link_mtu    <= value;
        @(posedge i_clk);
        i_link_mtu_we <= 1'b0;
        mtu_setting = value;
    endtask

    function automatic logic [7:0] rand_data();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_mtu();
        case ($urandom_range(9))
            0:       return 10'($urandom_range(0, 3));
            1:       return ($urandom_range(1) != 0) ? 10'd1023 : 10'd517;
            2:       return 10'($urandom_range(23, 1023));
            default: return 10'($urandom_range(4, 26));
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_byte(rand_data(), i == len - 1);
    endtask

    // Reset MTU of 23; one-byte frames with the extreme byte values.
    task automatic test_single_byte_frames();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_idle();
    endtask

    // Packet closed by the payload limit, then by the frame end.
    task automatic test_limit_close();
        set_mtu(10'd5);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b1);
        wait_idle();
    endtask

    // MTU at or below the header size gives a one-byte payload limit.
    task automatic test_tiny_mtu();
        logic [9:0] sizes[4] = '{10'd0, 10'd3, 10'd4, 10'd1};
        foreach (sizes[k]) begin
            set_mtu(sizes[k]);
            send_byte(rand_data(), 1'b0);
            send_byte(rand_data(), 1'b1);
        end
        wait_idle();
    endtask

    // Open packet already past the new limit: the next byte closes it.
    task automatic test_mtu_lowered_mid_packet();
        set_mtu(10'd23);
        for (int i = 0; i < 5; i++)
            send_byte(rand_data(), 1'b0);
        set_mtu(10'd6);
        send_byte(rand_data(), 1'b0);
        send_byte(rand_data(), 1'b1);
        wait_idle();
    endtask

    // MTU at and above the maximum; short frames closed by the frame end.
    task automatic test_mtu_clamp();
        logic [9:0] sizes[3] = '{10'd517, 10'd518, 10'd1023};
        foreach (sizes[k]) begin
            set_mtu(sizes[k]);
            send_frame(8);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int sent;
        int flen;
        sent = 0;
        while (sent < 220) begin
            if ($urandom_range(3) == 0)
                set_mtu(pick_mtu());
            stall_pct = $urandom_range(0, 60);
            gaps_on   = ($urandom_range(4) != 0);
            flen = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
            for (int i = 0; i < flen; i++) begin
                if ($urandom_range(30) == 0)
                    wait_idle();
                if ($urandom_range(40) == 0)
                    set_mtu(pick_mtu());
                send_byte(rand_data(), i == flen - 1);
                sent++;
            end
        end
        wait_idle();
        stall_pct = 30;
        gaps_on   = 1'b1;
    endtask

    initial begin
        pkt_num     = 16'd0;
        frag_idx    = 8'd0;
        open_bytes  = 10'd0;
        mtu_setting = 10'(ffh_pkg::LINK_MTU_RESET);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte_frames();
        test_limit_close();
        test_tiny_mtu();
        test_mtu_lowered_mid_packet();
        test_mtu_clamp();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
